// ===== src/tll_pkg.sv =====
// ----------------------------------------------------------------------------
// tll_pkg
// Shared types and constants for the tree leaf lister: controller states,
// controller-to-datapath commands and datapath status.
// ----------------------------------------------------------------------------
package tll_pkg;

   localparam int CHILD_W    = 5;   // signed child index, -1 = none
   localparam int LEAF_W     = 4;   // leaf index on the result channel
   localparam int RESULT_CAP = 16;  // leaves listed per tree at most
   localparam int CAP_W      = 5;   // holds 0 .. RESULT_CAP

   typedef enum logic [2:0] {
      ST_LOAD,    // taking node transfers
      ST_SCAN,    // looking for the root, one index a cycle
      ST_POP,     // dequeue next node
      ST_FETCH,   // read child tables at the dequeued node
      ST_CHECK,   // classify node, emit leaf or enqueue first child
      ST_ENQ_R,   // enqueue right child when both exist
      ST_FLUSH    // release held leaf as last, clear the tree
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic pop;
      logic fetch;
      logic check;
      logic enq_r;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic scan_none;
      logic scan_hit;
      logic walk_more;
      logic chk_hold;
      logic two_kids;
      logic flush_hold;
   } status_type;

endpackage

// ===== src/tll_ctrl.sv =====
// ----------------------------------------------------------------------------
// tll_ctrl
// Sequencer for the tree leaf lister: load, root scan, breadth-first walk
// and flush.
// ----------------------------------------------------------------------------
module tll_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last_node,
   input  tll_pkg::status_type sts,
   output tll_pkg::cmd_type    cmd
);

   tll_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tll_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         tll_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            if (req_valid && req_last_node) begin
               state_in = tll_pkg::ST_SCAN;
            end
         end
         tll_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_none) begin
               state_in = tll_pkg::ST_FLUSH;
            end else if (sts.scan_hit) begin
               state_in = tll_pkg::ST_POP;
            end
         end
         tll_pkg::ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = sts.walk_more ? tll_pkg::ST_FETCH : tll_pkg::ST_FLUSH;
         end
         tll_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = tll_pkg::ST_CHECK;
         end
         tll_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            if (!sts.chk_hold) begin
               state_in = sts.two_kids ? tll_pkg::ST_ENQ_R : tll_pkg::ST_POP;
            end
         end
         tll_pkg::ST_ENQ_R: begin
            cmd.enq_r = 1'b1;
            state_in  = tll_pkg::ST_POP;
         end
         tll_pkg::ST_FLUSH: begin
            cmd.flush = 1'b1;
            if (!sts.flush_hold) begin
               state_in = tll_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = tll_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

// ===== src/tll_dpath.sv =====
// ----------------------------------------------------------------------------
// tll_dpath
// Datapath of the tree leaf lister: child tables, parent marks, root scan
// counter, ring queue, held leaf and result register.
// ----------------------------------------------------------------------------
module tll_dpath #(
   parameter int MAX_NODES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tll_pkg::cmd_type                    cmd,
   output tll_pkg::status_type                 sts,
   input  logic                                req_valid,
   input  logic signed [tll_pkg::CHILD_W-1:0]  req_left_child,
   input  logic signed [tll_pkg::CHILD_W-1:0]  req_right_child,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [tll_pkg::LEAF_W-1:0]   rsp_leaf_index,
   output logic                                rsp_last_leaf
);

   localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int POS_W = CNT_W + 1;

   // child tables and walk queue
   logic signed [tll_pkg::CHILD_W-1:0] left_mem  [MAX_NODES];
   logic signed [tll_pkg::CHILD_W-1:0] right_mem [MAX_NODES];
   logic        [IDX_W-1:0]            queue_mem [MAX_NODES];

   logic signed [tll_pkg::CHILD_W-1:0] left_rd_ff, right_rd_ff;
   logic        [IDX_W-1:0]            q_data_ff;

   logic [MAX_NODES-1:0] has_parent_ff, has_parent_in;
   logic [CNT_W-1:0]     node_count_ff, node_count_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [CNT_W-1:0]     pops_ff, pops_in;
   logic [tll_pkg::CAP_W-1:0] count_ff, count_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]     pend_idx_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [tll_pkg::LEAF_W-1:0] rsp_leaf_ff;
   logic                 rsp_last_ff;

   logic             store_en, l_mark, r_mark;
   logic             pop_go, lv, rv, leaf, emit, emit_go, out_free, finish, out_load;
   logic             enq_en, enq_ok;
   logic [IDX_W-1:0] enq_node, left_idx, right_idx;
   logic [POS_W-1:0] pos_sum, pos_wrap;

   // ---------------------------------------------------------------- load
   assign store_en = cmd.load && req_valid && (32'(node_count_ff) < MAX_NODES);
   assign l_mark   = !req_left_child[tll_pkg::CHILD_W-1]
                     && (32'(req_left_child[tll_pkg::CHILD_W-2:0]) < MAX_NODES);
   assign r_mark   = !req_right_child[tll_pkg::CHILD_W-1]
                     && (32'(req_right_child[tll_pkg::CHILD_W-2:0]) < MAX_NODES);

   always_comb begin
      has_parent_in = has_parent_ff;
      if (finish) begin
         has_parent_in = '0;
      end else if (store_en) begin
         for (int i = 0; i < MAX_NODES; i++) begin
            if (l_mark && (32'(req_left_child[tll_pkg::CHILD_W-2:0]) == 32'(i))) begin
               has_parent_in[i] = 1'b1;
            end
            if (r_mark && (32'(req_right_child[tll_pkg::CHILD_W-2:0]) == 32'(i))) begin
               has_parent_in[i] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         left_mem[node_count_ff[IDX_W-1:0]]  <= req_left_child;
         right_mem[node_count_ff[IDX_W-1:0]] <= req_right_child;
      end
      if (cmd.fetch) begin
         left_rd_ff  <= left_mem[q_data_ff];
         right_rd_ff <= right_mem[q_data_ff];
      end
   end

   // ---------------------------------------------------------------- root scan
   assign sts.scan_none = (scan_ff >= node_count_ff);
   assign sts.scan_hit  = !sts.scan_none && !has_parent_ff[scan_ff[IDX_W-1:0]];

   // ---------------------------------------------------------------- walk
   assign sts.walk_more = (fill_ff != '0) && (pops_ff < node_count_ff);
   assign pop_go        = cmd.pop && sts.walk_more;

   // child counts only if it names a loaded node
   assign lv = !left_rd_ff[tll_pkg::CHILD_W-1]
               && (32'(left_rd_ff[tll_pkg::CHILD_W-2:0]) < 32'(node_count_ff));
   assign rv = !right_rd_ff[tll_pkg::CHILD_W-1]
               && (32'(right_rd_ff[tll_pkg::CHILD_W-2:0]) < 32'(node_count_ff));
   assign left_idx  = IDX_W'(32'(left_rd_ff[tll_pkg::CHILD_W-2:0]));
   assign right_idx = IDX_W'(32'(right_rd_ff[tll_pkg::CHILD_W-2:0]));

   assign leaf         = !lv && !rv;
   assign emit         = cmd.check && leaf && (32'(count_ff) < tll_pkg::RESULT_CAP);
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign sts.chk_hold = emit && pend_valid_ff && !out_free;
   assign emit_go      = emit && !sts.chk_hold;
   assign sts.two_kids = lv && rv;

   assign sts.flush_hold = cmd.flush && pend_valid_ff && !out_free;
   assign finish         = cmd.flush && !sts.flush_hold;

   always_comb begin
      enq_en   = 1'b0;
      enq_node = right_idx;
      if (cmd.scan && sts.scan_hit) begin
         enq_en   = 1'b1;
         enq_node = scan_ff[IDX_W-1:0];
      end else if (cmd.check && (lv || rv)) begin
         enq_en   = 1'b1;
         enq_node = lv ? left_idx : right_idx;
      end else if (cmd.enq_r) begin
         enq_en   = 1'b1;
         enq_node = right_idx;
      end
   end

   // a full ring drops the enqueue
   assign enq_ok   = enq_en && (32'(fill_ff) < MAX_NODES);
   assign pos_sum  = POS_W'(head_ff) + POS_W'(fill_ff);
   assign pos_wrap = (32'(pos_sum) >= MAX_NODES) ? (pos_sum - POS_W'(MAX_NODES)) : pos_sum;

   always_ff @(posedge clock) begin
      if (enq_ok) begin
         queue_mem[pos_wrap[IDX_W-1:0]] <= enq_node;
      end
      if (pop_go) begin
         q_data_ff <= queue_mem[head_ff];
      end
   end

   always_comb begin
      node_count_in = node_count_ff;
      scan_in       = scan_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      pops_in       = pops_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      if (finish) begin
         node_count_in = '0;
         scan_in       = '0;
         head_in       = '0;
         fill_in       = '0;
         pops_in       = '0;
         count_in      = '0;
         pend_valid_in = 1'b0;
      end else begin
         if (store_en) begin
            node_count_in = node_count_ff + 1'b1;
         end
         if (cmd.scan && !sts.scan_none && !sts.scan_hit) begin
            scan_in = scan_ff + 1'b1;
         end
         if (pop_go) begin
            head_in = (32'(head_ff) == MAX_NODES - 1) ? '0 : head_ff + 1'b1;
            fill_in = fill_ff - 1'b1;
            pops_in = pops_ff + 1'b1;
         end else if (enq_ok) begin
            fill_in = fill_ff + 1'b1;
         end
         if (emit_go) begin
            count_in      = count_ff + 1'b1;
            pend_valid_in = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- result
   // a leaf is held back one step so the final one can carry the last flag
   assign out_load = pend_valid_ff && (emit_go || finish);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         pend_idx_ff <= q_data_ff;
      end
      if (out_load) begin
         rsp_leaf_ff <= tll_pkg::LEAF_W'(32'(pend_idx_ff));
         rsp_last_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_parent_ff <= '0;
         node_count_ff <= '0;
         scan_ff       <= '0;
         head_ff       <= '0;
         fill_ff       <= '0;
         pops_ff       <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         has_parent_ff <= has_parent_in;
         node_count_ff <= node_count_in;
         scan_ff       <= scan_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         pops_ff       <= pops_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_leaf_index = rsp_leaf_ff;
   assign rsp_last_leaf  = rsp_last_ff;

endmodule

// ===== src/tree_leaf_lister_bfs.sv =====
// ----------------------------------------------------------------------------
// tree_leaf_lister_bfs
// Loads a binary tree one node per transfer and lists its leaves in level
// order, flagging the final leaf.
// ----------------------------------------------------------------------------
// Nodes are loaded at one transfer per cycle; req_stall rises after the
// transfer that carries req_last_node and stays high until the tree has been
// listed. The root scan then checks node indices in turn, up to the node
// count, and the breadth-first walk takes each dequeued node through queue
// read, child-table read and classify, plus a right-child enqueue for a node
// with two loaded children, since the ring queue has a single write port; a
// flush step ends the tree. Leaves leave through an output register, loaded
// from the held leaf when the next leaf is emitted or at flush, so the walk
// runs on while a result waits; at most 16 leaves are listed.
module tree_leaf_lister_bfs #(
   parameter int MAX_NODES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [tll_pkg::CHILD_W-1:0]  req_left_child,
   input  logic signed [tll_pkg::CHILD_W-1:0]  req_right_child,
   input  logic                                req_last_node,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [tll_pkg::LEAF_W-1:0]   rsp_leaf_index,
   output logic                                rsp_last_leaf
);

   tll_pkg::cmd_type    cmd;
   tll_pkg::status_type sts;

   tll_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_node (req_last_node),
      .sts           (sts),
      .cmd           (cmd)
   );

   tll_dpath #(
      .MAX_NODES (MAX_NODES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_valid       (req_valid),
      .req_left_child  (req_left_child),
      .req_right_child (req_right_child),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_leaf_index  (rsp_leaf_index),
      .rsp_last_leaf   (rsp_last_leaf)
   );

   assign req_stall = !cmd.load;

   // the final node of a tree closes the input until the walk is done
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_node) |=> req_stall)
      else $error("input still open after final node transfer");

   // results are produced only during the walk
   a_rsp_in_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while loading");

   // the walk only waits on a stalled, full result register
   a_hold_cause: assert property (@(posedge clock) disable iff (reset)
      (sts.chk_hold || sts.flush_hold) |-> (rsp_valid && rsp_stall))
      else $error("walk held without a stalled result");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for tree_leaf_lister_bfs. Trees are built, queued
// as node transfers and driven over the request channel; a predictor
// finds the root and walks each tree in level order to build the expected
// leaf list, and the monitor checks every result transfer against it.
// Runs through four phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int MAX_NODES   = 16;
   localparam int QUIET_LIMIT = 3000;  // cycles with no transfer on either side
   localparam int DRAIN_WAIT  = 200;   // walk of a full tree plus stalls

   typedef struct packed {
      logic signed [tll_pkg::CHILD_W-1:0] left;
      logic signed [tll_pkg::CHILD_W-1:0] right;
      logic                               last;
   } node_type;

   typedef struct packed {
      logic [tll_pkg::LEAF_W-1:0] leaf_index;
      logic                       last_leaf;
   } leaf_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic signed [tll_pkg::CHILD_W-1:0] req_left_child = '0;
   logic signed [tll_pkg::CHILD_W-1:0] req_right_child = '0;
   logic                               req_last_node = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [tll_pkg::LEAF_W-1:0]         rsp_leaf_index;
   logic                               rsp_last_leaf;

   node_type node_q [$];      // node transfers waiting to be driven
   leaf_type leaf_q [$];      // leaves expected, oldest first
   node_type drv_item;
   leaf_type mon_exp;

   // predictor state
   logic signed [tll_pkg::CHILD_W-1:0] left_tab  [MAX_NODES];
   logic signed [tll_pkg::CHILD_W-1:0] right_tab [MAX_NODES];
   logic                               has_par   [MAX_NODES];
   int                                 node_cnt = 0;

   int idle_pct = 0;
   int stall_pct = 0;
   int fail_cnt = 0;
   int quiet = 0;
   int nodes_sent = 0;
   int trees_done = 0;
   int leaves_checked = 0;
   int ph;
   int added;

   tree_leaf_lister_bfs #(.MAX_NODES(MAX_NODES)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_child  (req_left_child),
      .req_right_child (req_right_child),
      .req_last_node   (req_last_node),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_leaf_index  (rsp_leaf_index),
      .rsp_last_leaf   (rsp_last_leaf)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Store one node; on the last node find the root and list the leaves
   // breadth-first through a bounded ring.
   task automatic load_and_list(input logic signed [tll_pkg::CHILD_W-1:0] l,
                                input logic signed [tll_pkg::CHILD_W-1:0] r,
                                input logic last);
      int lc, rc, root, pops, n, head, fill, cnt;
      bit lv, rv;
      int ring [MAX_NODES];
      int leaves [tll_pkg::RESULT_CAP];
      leaf_type lf;
      lc = int'(l);
      rc = int'(r);
      if (node_cnt < MAX_NODES) begin
         left_tab[node_cnt]  = l;
         right_tab[node_cnt] = r;
         if (lc >= 0) has_par[lc] = 1'b1;
         if (rc >= 0) has_par[rc] = 1'b1;
         node_cnt++;
      end
      if (last) begin
         root = 0;
         while (root < node_cnt && has_par[root]) root++;
         if (root < node_cnt) begin
            ring[0] = root;
            head = 0;
            fill = 1;
            pops = 0;
            cnt = 0;
            // a malformed tree stops after node_cnt dequeues
            while (fill > 0 && pops < node_cnt) begin
               n = ring[head];
               head = (head + 1) % MAX_NODES;
               fill--;
               pops++;
               lc = int'(left_tab[n]);
               rc = int'(right_tab[n]);
               lv = (lc >= 0 && lc < node_cnt);
               rv = (rc >= 0 && rc < node_cnt);
               if (!lv && !rv && cnt < tll_pkg::RESULT_CAP) begin
                  leaves[cnt] = n;
                  cnt++;
               end
               if (lv && fill < MAX_NODES) begin
                  ring[(head + fill) % MAX_NODES] = lc;
                  fill++;
               end
               if (rv && fill < MAX_NODES) begin
                  ring[(head + fill) % MAX_NODES] = rc;
                  fill++;
               end
            end
            for (int i = 0; i < cnt; i++) begin
               lf.leaf_index = tll_pkg::LEAF_W'(leaves[i]);
               lf.last_leaf  = (i == cnt - 1);
               leaf_q.push_back(lf);
            end
         end
         for (int i = 0; i < MAX_NODES; i++) has_par[i] = 1'b0;
         node_cnt = 0;
         trees_done++;
      end
   endtask

   function automatic void push_node(input int l, input int r, input bit last);
      node_type nd;
      nd.left  = tll_pkg::CHILD_W'(l);
      nd.right = tll_pkg::CHILD_W'(r);
      nd.last  = last;
      node_q.push_back(nd);
   endfunction

   // absent child: mostly -1, sometimes another negative code
   function automatic int no_child();
      if ($urandom_range(99, 0) < 80) return -1;
      return -int'($urandom_range(16, 2));
   endfunction

   // Random well-formed tree of n nodes with a shuffled numbering.
   function automatic int add_good_tree(input int n);
      int perm [MAX_NODES];
      int lch [MAX_NODES];
      int rch [MAX_NODES];
      int cand [$];
      int j, t, p;
      for (int i = 0; i < n; i++) begin
         perm[i] = i;
         lch[i] = -1;
         rch[i] = -1;
      end
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(i, 0);
         t = perm[i];
         perm[i] = perm[j];
         perm[j] = t;
      end
      for (int i = 1; i < n; i++) begin
         cand.delete();
         for (int k = 0; k < i; k++)
            if (lch[perm[k]] < 0 || rch[perm[k]] < 0) cand.push_back(perm[k]);
         p = cand[$urandom_range(cand.size() - 1, 0)];
         if (lch[p] < 0 && (rch[p] >= 0 || $urandom_range(1, 0)))
            lch[p] = perm[i];
         else
            rch[p] = perm[i];
      end
      for (int i = 0; i < n; i++)
         push_node(lch[i] < 0 ? no_child() : lch[i],
                   rch[i] < 0 ? no_child() : rch[i], i == n - 1);
      return n;
   endfunction

   // Noise: arbitrary links, shared children, cycles, overlong trees.
   function automatic int add_noise_tree(input int n);
      int l, r;
      for (int i = 0; i < n; i++) begin
         l = $urandom_range(1, 0) ? $urandom_range(15, 0) : $urandom_range(31, 0);
         r = $urandom_range(1, 0) ? $urandom_range(15, 0) : $urandom_range(31, 0);
         push_node(l, r, i == n - 1);
      end
      return n;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            load_and_list(req_left_child, req_right_child, req_last_node);
            nodes_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (node_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
               drv_item = node_q.pop_front();
               req_valid       <= 1'b1;
               req_left_child  <= drv_item.left;
               req_right_child <= drv_item.right;
               req_last_node   <= drv_item.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (leaf_q.size() == 0) begin
               $error("unexpected leaf transfer: leaf_index %0d last_leaf %0d",
                      rsp_leaf_index, rsp_last_leaf);
               fail_cnt++;
            end else begin
               mon_exp = leaf_q.pop_front();
               leaves_checked++;
               if (rsp_leaf_index !== mon_exp.leaf_index) begin
                  $error("leaf_index: expected %0d, got %0d",
                         mon_exp.leaf_index, rsp_leaf_index);
                  fail_cnt++;
               end
               if (rsp_last_leaf !== mon_exp.last_leaf) begin
                  $error("last_leaf: expected %0d, got %0d",
                         mon_exp.last_leaf, rsp_last_leaf);
                  fail_cnt++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d leaves outstanding",
                  quiet, leaf_q.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      for (int i = 0; i < MAX_NODES; i++) has_par[i] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 87; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 87; end
            default: begin idle_pct = 11; stall_pct = 11; end
         endcase
         if (ph == 0) begin
            push_node(-1, -1, 1);                         // lone root
            push_node(-16, -5, 1);                        // odd negative codes
            push_node(1, 2, 0);
            push_node(-1, -1, 0);
            push_node(-1, -1, 1);
            push_node(1, -1, 0);                          // every node has a parent
            push_node(0, -1, 1);
            push_node(15, 3, 1);                          // children never loaded
            push_node(-1, -1, 0);                         // root is not node 0
            push_node(0, -1, 1);
            push_node(1, 1, 0);                           // shared child
            push_node(-1, -1, 1);
            push_node(1, -1, 0);                          // cycle below the root
            push_node(2, -1, 0);
            push_node(1, -1, 1);
            push_node(2, 1, 0);                           // leaves in level order
            push_node(-1, -1, 0);
            push_node(3, 4, 0);
            push_node(-1, -1, 0);
            push_node(-1, -1, 1);
         end
         added = 0;
         while (added < 48) begin
            if ($urandom_range(99, 0) < 75)
               added += add_good_tree($urandom_range(99, 0) < 85 ?
                                      $urandom_range(8, 1) : $urandom_range(16, 9));
            else
               added += add_noise_tree($urandom_range(99, 0) < 80 ?
                                       $urandom_range(8, 1) : $urandom_range(20, 9));
         end
         while (node_q.size() != 0 || req_valid || leaf_q.size() != 0)
            @(negedge clock);
      end

      repeat (DRAIN_WAIT) @(negedge clock);
      if (leaf_q.size() != 0) begin
         $error("%0d expected leaves never arrived", leaf_q.size());
         fail_cnt++;
      end
      $display("Sent %0d trees in %0d node transfers, checked %0d leaves,", trees_done,
               nodes_sent, leaves_checked);
      $display("over free-running, idle sender, stalled receiver and mixed phases.");
      if (fail_cnt == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
src/tll_pkg.sv
src/tll_ctrl.sv
src/tll_dpath.sv
src/tree_leaf_lister_bfs.sv
test/tb_top.sv
